/* design/boc_pkg.sv */
// Shared types and constants of the bytecode operand checker: opcode numbering,
// error codes, constant kinds, register indexes and the configuration struct.
// Used by every other file of the block except boc_ram.sv; depends on nothing.
`default_nettype none

package boc_pkg;

   // Widths fixed by the item fields and the configuration registers.
   localparam int unsigned PC_WIDTH      = 12;
   localparam int unsigned OPCODE_WIDTH  = 6;
   localparam int unsigned OPERAND_WIDTH = 32;
   localparam int unsigned KIND_WIDTH    = 2;
   localparam int unsigned ERROR_WIDTH   = 5;
   localparam int unsigned REG_CNT_WIDTH = 9;
   localparam int unsigned CNT_WIDTH     = 13;

   // Configuration port.
   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic [1:0] CSR_IDX_REG_COUNT   = 2'd0;
   localparam logic [1:0] CSR_IDX_INSN_COUNT  = 2'd1;
   localparam logic [1:0] CSR_IDX_CONST_COUNT = 2'd2;

   // Commands.
   localparam logic CMD_WRITE_KIND = 1'b0;
   localparam logic CMD_CHECK      = 1'b1;

   // Constant kinds.
   localparam logic [1:0] KIND_INT  = 2'd0;
   localparam logic [1:0] KIND_ATOM = 2'd1;
   localparam logic [1:0] KIND_FUNC = 2'd2;

   // Highest valid term kind for istype.
   localparam logic [2:0] TERM_KIND_MAX = 3'd4;

   // Opcodes, numbered densely.
   localparam logic [5:0] OP_LOADK            = 6'd0;
   localparam logic [5:0] OP_MOVE             = 6'd1;
   localparam logic [5:0] OP_TUPLE            = 6'd2;
   localparam logic [5:0] OP_JUMP             = 6'd3;
   localparam logic [5:0] OP_CALL             = 6'd4;
   localparam logic [5:0] OP_TAILCALL         = 6'd5;
   localparam logic [5:0] OP_RETURN           = 6'd6;
   localparam logic [5:0] OP_TESTATOM         = 6'd7;
   localparam logic [5:0] OP_TESTINT          = 6'd8;
   localparam logic [5:0] OP_TESTEQ           = 6'd9;
   localparam logic [5:0] OP_TESTARITY        = 6'd10;
   localparam logic [5:0] OP_GETELEM          = 6'd11;
   localparam logic [5:0] OP_ADD              = 6'd12;
   localparam logic [5:0] OP_SUB              = 6'd13;
   localparam logic [5:0] OP_MUL              = 6'd14;
   localparam logic [5:0] OP_DIV              = 6'd15;
   localparam logic [5:0] OP_REM              = 6'd16;
   localparam logic [5:0] OP_LT               = 6'd17;
   localparam logic [5:0] OP_LE               = 6'd18;
   localparam logic [5:0] OP_GT               = 6'd19;
   localparam logic [5:0] OP_GE               = 6'd20;
   localparam logic [5:0] OP_FAIL             = 6'd21;
   localparam logic [5:0] OP_SELF             = 6'd22;
   localparam logic [5:0] OP_MAKEREF          = 6'd23;
   localparam logic [5:0] OP_SEND             = 6'd24;
   localparam logic [5:0] OP_SPAWN            = 6'd25;
   localparam logic [5:0] OP_RECVBEGIN        = 6'd26;
   localparam logic [5:0] OP_RECVNEXT         = 6'd27;
   localparam logic [5:0] OP_RECVTAKE         = 6'd28;
   localparam logic [5:0] OP_RECVWAIT         = 6'd29;
   localparam logic [5:0] OP_RECVDEADLINE     = 6'd30;
   localparam logic [5:0] OP_RECVWAITDEADLINE = 6'd31;
   localparam logic [5:0] OP_EXIT             = 6'd32;
   localparam logic [5:0] OP_PRINT            = 6'd33;
   localparam logic [5:0] OP_EPRINT           = 6'd34;
   localparam logic [5:0] OP_GUARD            = 6'd35;
   localparam logic [5:0] OP_GUARDEND         = 6'd36;
   localparam logic [5:0] OP_ISTYPE           = 6'd37;
   localparam logic [5:0] OP_NOP              = 6'd38;

   // Error codes.
   localparam logic [4:0] ERR_NONE        = 5'd0;
   localparam logic [4:0] ERR_OPCODE      = 5'd1;
   localparam logic [4:0] ERR_LOADK       = 5'd2;
   localparam logic [4:0] ERR_MOVE        = 5'd3;
   localparam logic [4:0] ERR_TUPLE       = 5'd4;
   localparam logic [4:0] ERR_JUMP        = 5'd5;
   localparam logic [4:0] ERR_CALL        = 5'd6;
   localparam logic [4:0] ERR_TAILCALL    = 5'd7;
   localparam logic [4:0] ERR_RETURN      = 5'd8;
   localparam logic [4:0] ERR_TESTATOM    = 5'd9;
   localparam logic [4:0] ERR_TESTINT     = 5'd10;
   localparam logic [4:0] ERR_TESTEQ      = 5'd11;
   localparam logic [4:0] ERR_TESTARITY   = 5'd12;
   localparam logic [4:0] ERR_GETELEM     = 5'd13;
   localparam logic [4:0] ERR_ARITH       = 5'd14;
   localparam logic [4:0] ERR_FAIL        = 5'd15;
   localparam logic [4:0] ERR_PROC_DEST   = 5'd16;
   localparam logic [4:0] ERR_SEND        = 5'd17;
   localparam logic [4:0] ERR_SPAWN       = 5'd18;
   localparam logic [4:0] ERR_RECV_DEST   = 5'd19;
   localparam logic [4:0] ERR_RECV_RETRY  = 5'd20;
   localparam logic [4:0] ERR_RECV_DLINE  = 5'd21;
   localparam logic [4:0] ERR_EXIT        = 5'd22;
   localparam logic [4:0] ERR_PRINT       = 5'd23;
   localparam logic [4:0] ERR_EPRINT      = 5'd24;
   localparam logic [4:0] ERR_GUARD       = 5'd25;
   localparam logic [4:0] ERR_ISTYPE      = 5'd26;

   // Function limits held in the configuration registers.
   typedef struct packed {
      logic [REG_CNT_WIDTH-1:0] reg_count;
      logic [CNT_WIDTH-1:0]     insn_count;
      logic [CNT_WIDTH-1:0]     const_count;
   } cfg_type;

endpackage

`default_nettype wire

/* design/boc_intf.sv */
// Valid/ready channel interfaces of the bytecode operand checker: the request
// channel carrying one instruction or table write, and the response channel.
// Depends on boc_pkg for field widths.
`default_nettype none

interface boc_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      command;
   logic [boc_pkg::PC_WIDTH-1:0]              pc_tag;
   logic [boc_pkg::OPCODE_WIDTH-1:0]          opcode;
   logic signed [boc_pkg::OPERAND_WIDTH-1:0]  operand_a;
   logic signed [boc_pkg::OPERAND_WIDTH-1:0]  operand_b;
   logic signed [boc_pkg::OPERAND_WIDTH-1:0]  operand_c;
   logic [boc_pkg::KIND_WIDTH-1:0]            const_kind;

   modport source (
      output valid, command, pc_tag, opcode, operand_a, operand_b, operand_c, const_kind,
      input  ready
   );
   modport sink (
      input  valid, command, pc_tag, opcode, operand_a, operand_b, operand_c, const_kind,
      output ready
   );
endinterface

interface boc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             accepted;
   logic [boc_pkg::ERROR_WIDTH-1:0]  error_code;
   logic [boc_pkg::PC_WIDTH-1:0]     pc_out;

   modport source (
      output valid, accepted, error_code, pc_out,
      input  ready
   );
   modport sink (
      input  valid, accepted, error_code, pc_out,
      output ready
   );
endinterface

`default_nettype wire

/* design/bytecode_operand_checker.sv */
// Bytecode operand checker, top level. An accepted item is registered in stage one, and
// its result then in the result register, from which it is taken.
// Throughput: one item per cycle, set by the single table read port and the combinational
// check logic; the input stalls only while both stages are full and the result waits.
// Reset (synchronous, active high) empties both stages and restores reg_count 1,
// insn_count 1, const_count 0; the kind table is not cleared and is undefined until written.
`default_nettype none

module bytecode_operand_checker #(
   parameter int unsigned MAX_ITEMS = 4096
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   boc_req_if.sink                                     req_if,
   boc_rsp_if.source                                   rsp_if,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [boc_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  wire logic [boc_pkg::CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [boc_pkg::CSR_DATA_WIDTH-1:0]          prdata,
   output logic                                        pready
);

   localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes complete in the access phase; pready is
   // tied high so no wait states are ever inserted.
   // ---------------------------------------------------------------------
   boc_pkg::cfg_type cfg_ff, cfg_in;
   logic             csr_write;
   logic [1:0]       csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            boc_pkg::CSR_IDX_REG_COUNT:
               cfg_in.reg_count = pwdata[boc_pkg::REG_CNT_WIDTH-1:0];
            boc_pkg::CSR_IDX_INSN_COUNT:
               cfg_in.insn_count = pwdata[boc_pkg::CNT_WIDTH-1:0];
            boc_pkg::CSR_IDX_CONST_COUNT:
               cfg_in.const_count = pwdata[boc_pkg::CNT_WIDTH-1:0];
            default: begin
               // Addresses beyond the register list are ignored.
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         boc_pkg::CSR_IDX_REG_COUNT:   prdata = 32'(cfg_ff.reg_count);
         boc_pkg::CSR_IDX_INSN_COUNT:  prdata = 32'(cfg_ff.insn_count);
         boc_pkg::CSR_IDX_CONST_COUNT: prdata = 32'(cfg_ff.const_count);
         default:                      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reg_count   <= boc_pkg::REG_CNT_WIDTH'(1);
         cfg_ff.insn_count  <= boc_pkg::CNT_WIDTH'(1);
         cfg_ff.const_count <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------------
   // Handshake. Stage one holds the accepted item while the table read
   // completes; the result register holds the finished item until taken.
   // A new item enters whenever stage one is empty or moving on, so while a
   // result waits downstream the block can still take one item into an empty stage one.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_free, s1_move, req_take;

   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign s1_move      = s1_valid_ff && rsp_free;
   assign req_if.ready = !s1_valid_ff || rsp_free;
   assign req_take     = req_if.valid && req_if.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !rsp_free);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------------
   // Constant-kind table. A write item stores its kind as it is accepted;
   // a check item reads the entry named by its constant operand in the same
   // cycle, so the kind is ready alongside the item in stage one. Since at
   // most one item enters per cycle, a check always sees earlier writes.
   // ---------------------------------------------------------------------
   logic [31:0]                     pc_wide;
   logic [31:0]                     key_wide;
   logic                            wr_in_range;
   logic                            tbl_wr_en;
   logic [boc_pkg::KIND_WIDTH-1:0]  tbl_kind;

   assign pc_wide     = 32'(req_if.pc_tag);
   assign key_wide    = (req_if.opcode == boc_pkg::OP_TAILCALL) ? req_if.operand_a
                                                                 : req_if.operand_b;
   assign wr_in_range = pc_wide < 32'(MAX_ITEMS);
   assign tbl_wr_en   = req_take && (req_if.command == boc_pkg::CMD_WRITE_KIND) && wr_in_range;

   boc_ram #(
      .WIDTH (boc_pkg::KIND_WIDTH),
      .DEPTH (MAX_ITEMS)
   ) u_kind_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (pc_wide[AW-1:0]),
      .wr_data (req_if.const_kind),
      .rd_en   (req_take),
      .rd_addr (key_wide[AW-1:0]),
      .rd_data (tbl_kind)
   );

   // ---------------------------------------------------------------------
   // Stage one payload.
   // ---------------------------------------------------------------------
   logic                                      s1_command_ff;
   logic                                      s1_wr_ok_ff;
   logic [boc_pkg::PC_WIDTH-1:0]              s1_pc_ff;
   logic [boc_pkg::OPCODE_WIDTH-1:0]          s1_opcode_ff;
   logic signed [boc_pkg::OPERAND_WIDTH-1:0]  s1_a_ff, s1_b_ff, s1_c_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff <= req_if.command;
         s1_wr_ok_ff   <= wr_in_range;
         s1_pc_ff      <= req_if.pc_tag;
         s1_opcode_ff  <= req_if.opcode;
         s1_a_ff       <= req_if.operand_a;
         s1_b_ff       <= req_if.operand_b;
         s1_c_ff       <= req_if.operand_c;
      end
   end

   // ---------------------------------------------------------------------
   // Operand checks and result register. A write item passes when its index
   // fell inside the table and never carries an error code.
   // ---------------------------------------------------------------------
   logic [boc_pkg::ERROR_WIDTH-1:0] chk_error;
   logic [boc_pkg::ERROR_WIDTH-1:0] rsp_error_ff, rsp_error_in;
   logic                            rsp_accepted_ff, rsp_accepted_in;
   logic [boc_pkg::PC_WIDTH-1:0]    rsp_pc_ff;

   boc_check #(
      .MAX_ITEMS (MAX_ITEMS)
   ) u_check (
      .cfg        (cfg_ff),
      .opcode     (s1_opcode_ff),
      .operand_a  (s1_a_ff),
      .operand_b  (s1_b_ff),
      .operand_c  (s1_c_ff),
      .table_kind (tbl_kind),
      .error_code (chk_error)
   );

   always_comb begin
      if (s1_command_ff == boc_pkg::CMD_CHECK) begin
         rsp_error_in    = chk_error;
         rsp_accepted_in = (chk_error == boc_pkg::ERR_NONE);
      end else begin
         rsp_error_in    = boc_pkg::ERR_NONE;
         rsp_accepted_in = s1_wr_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_error_ff    <= rsp_error_in;
         rsp_accepted_ff <= rsp_accepted_in;
         rsp_pc_ff       <= s1_pc_ff;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.accepted   = rsp_accepted_ff;
   assign rsp_if.error_code = rsp_error_ff;
   assign rsp_if.pc_out     = rsp_pc_ff;

endmodule

`default_nettype wire

/* design/boc_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read and
// read enable. No reset; contents are undefined until written. No dependencies.
`default_nettype none

module boc_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 4096
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/boc_check.sv */
// Combinational operand checker: maps one registered instruction, the function
// limits and the looked-up constant kind to an error code. Depends on boc_pkg.
`default_nettype none

module boc_check #(
   parameter int unsigned MAX_ITEMS = 4096
) (
   input  wire boc_pkg::cfg_type                            cfg,
   input  wire logic [boc_pkg::OPCODE_WIDTH-1:0]            opcode,
   input  wire logic signed [boc_pkg::OPERAND_WIDTH-1:0]    operand_a,
   input  wire logic signed [boc_pkg::OPERAND_WIDTH-1:0]    operand_b,
   input  wire logic signed [boc_pkg::OPERAND_WIDTH-1:0]    operand_c,
   input  wire logic [boc_pkg::KIND_WIDTH-1:0]              table_kind,
   output logic [boc_pkg::ERROR_WIDTH-1:0]                  error_code
);

   logic       a_reg, b_reg, c_reg;
   logic       a_tgt, c_tgt;
   logic       a_idx;
   logic       b_nonneg, c_nonneg;
   logic       kind_hit;      // the looked-up constant exists and lies in the table
   logic [boc_pkg::OPERAND_WIDTH-1:0] key;
   logic       tuple_b_ok, tuple_c_ok;
   logic [boc_pkg::REG_CNT_WIDTH-1:0] tuple_room;
   logic       term_ok;

   // Non-negative and strictly below a count.
   function automatic logic below(input logic [31:0] x, input logic [31:0] lim);
      below = !x[31] && (x < lim);
   endfunction

   always_comb begin
      a_reg    = below(operand_a, 32'(cfg.reg_count));
      b_reg    = below(operand_b, 32'(cfg.reg_count));
      c_reg    = below(operand_c, 32'(cfg.reg_count));
      a_tgt    = below(operand_a, 32'(cfg.insn_count));
      c_tgt    = below(operand_c, 32'(cfg.insn_count));
      a_idx    = below(operand_a, 32'(cfg.const_count));
      b_nonneg = !operand_b[31];
      c_nonneg = !operand_c[31];

      // Tail calls name their constant in operand a, everything else in b.
      key      = (opcode == boc_pkg::OP_TAILCALL) ? operand_a : operand_b;
      kind_hit = below(key, 32'(cfg.const_count)) && below(key, 32'(MAX_ITEMS));

      // Tuple: 0 <= b <= n and 0 <= c <= n - b; b fits in the count width once in range.
      tuple_b_ok = b_nonneg && (operand_b <= $signed(32'(cfg.reg_count)));
      tuple_room = cfg.reg_count - operand_b[boc_pkg::REG_CNT_WIDTH-1:0];
      tuple_c_ok = c_nonneg && (operand_c <= $signed(32'(tuple_room)));

      term_ok  = c_nonneg && (operand_c <= $signed(32'(boc_pkg::TERM_KIND_MAX)));

      case (opcode)
         boc_pkg::OP_LOADK:
            error_code = (a_reg && below(operand_b, 32'(cfg.const_count))) ?
                         boc_pkg::ERR_NONE : boc_pkg::ERR_LOADK;
         boc_pkg::OP_MOVE:
            error_code = (a_reg && b_reg) ? boc_pkg::ERR_NONE : boc_pkg::ERR_MOVE;
         boc_pkg::OP_TUPLE:
            error_code = (a_reg && tuple_b_ok && tuple_c_ok) ?
                         boc_pkg::ERR_NONE : boc_pkg::ERR_TUPLE;
         boc_pkg::OP_JUMP:
            error_code = a_tgt ? boc_pkg::ERR_NONE : boc_pkg::ERR_JUMP;
         boc_pkg::OP_CALL:
            error_code = (a_reg && kind_hit && table_kind == boc_pkg::KIND_FUNC && c_reg) ?
                         boc_pkg::ERR_NONE : boc_pkg::ERR_CALL;
         boc_pkg::OP_TAILCALL:
            error_code = (kind_hit && table_kind == boc_pkg::KIND_FUNC && b_reg) ?
                         boc_pkg::ERR_NONE : boc_pkg::ERR_TAILCALL;
         boc_pkg::OP_RETURN:
            error_code = a_reg ? boc_pkg::ERR_NONE : boc_pkg::ERR_RETURN;
         boc_pkg::OP_TESTATOM:
            error_code = (a_reg && kind_hit && table_kind == boc_pkg::KIND_ATOM && c_tgt) ?
                         boc_pkg::ERR_NONE : boc_pkg::ERR_TESTATOM;
         boc_pkg::OP_TESTINT:
            error_code = (a_reg && kind_hit && table_kind == boc_pkg::KIND_INT && c_tgt) ?
                         boc_pkg::ERR_NONE : boc_pkg::ERR_TESTINT;
         boc_pkg::OP_TESTEQ:
            error_code = (a_reg && b_reg && c_tgt) ? boc_pkg::ERR_NONE : boc_pkg::ERR_TESTEQ;
         boc_pkg::OP_TESTARITY:
            error_code = (a_reg && b_nonneg && c_tgt) ?
                         boc_pkg::ERR_NONE : boc_pkg::ERR_TESTARITY;
         boc_pkg::OP_GETELEM:
            error_code = (a_reg && b_reg && c_nonneg) ?
                         boc_pkg::ERR_NONE : boc_pkg::ERR_GETELEM;
         boc_pkg::OP_ADD, boc_pkg::OP_SUB, boc_pkg::OP_MUL, boc_pkg::OP_DIV,
         boc_pkg::OP_REM, boc_pkg::OP_LT, boc_pkg::OP_LE, boc_pkg::OP_GT,
         boc_pkg::OP_GE:
            error_code = (a_reg && b_reg && c_reg) ? boc_pkg::ERR_NONE : boc_pkg::ERR_ARITH;
         boc_pkg::OP_FAIL:
            error_code = a_idx ? boc_pkg::ERR_NONE : boc_pkg::ERR_FAIL;
         boc_pkg::OP_SELF, boc_pkg::OP_MAKEREF:
            error_code = a_reg ? boc_pkg::ERR_NONE : boc_pkg::ERR_PROC_DEST;
         boc_pkg::OP_SEND:
            error_code = (a_reg && b_reg && c_reg) ? boc_pkg::ERR_NONE : boc_pkg::ERR_SEND;
         boc_pkg::OP_SPAWN:
            error_code = (a_reg && kind_hit && table_kind == boc_pkg::KIND_FUNC && c_reg) ?
                         boc_pkg::ERR_NONE : boc_pkg::ERR_SPAWN;
         boc_pkg::OP_RECVBEGIN, boc_pkg::OP_RECVNEXT:
            error_code = (a_reg && b_reg && (operand_a != operand_b)) ?
                         boc_pkg::ERR_NONE : boc_pkg::ERR_RECV_DEST;
         boc_pkg::OP_RECVTAKE, boc_pkg::OP_GUARDEND, boc_pkg::OP_NOP:
            error_code = boc_pkg::ERR_NONE;
         boc_pkg::OP_RECVWAIT, boc_pkg::OP_RECVWAITDEADLINE:
            error_code = a_tgt ? boc_pkg::ERR_NONE : boc_pkg::ERR_RECV_RETRY;
         boc_pkg::OP_RECVDEADLINE:
            error_code = a_reg ? boc_pkg::ERR_NONE : boc_pkg::ERR_RECV_DLINE;
         boc_pkg::OP_EXIT:
            error_code = a_reg ? boc_pkg::ERR_NONE : boc_pkg::ERR_EXIT;
         boc_pkg::OP_PRINT:
            error_code = (a_reg && b_reg) ? boc_pkg::ERR_NONE : boc_pkg::ERR_PRINT;
         boc_pkg::OP_EPRINT:
            error_code = (a_reg && b_reg) ? boc_pkg::ERR_NONE : boc_pkg::ERR_EPRINT;
         boc_pkg::OP_GUARD:
            error_code = a_tgt ? boc_pkg::ERR_NONE : boc_pkg::ERR_GUARD;
         boc_pkg::OP_ISTYPE:
            error_code = (a_reg && b_reg && term_ok) ? boc_pkg::ERR_NONE : boc_pkg::ERR_ISTYPE;
         default:
            error_code = boc_pkg::ERR_OPCODE;
      endcase
   end

endmodule

`default_nettype wire

/* tb/boc_result_monitor.sv */
// Result monitor for the bytecode operand checker: follows the configuration port and
// both item channels, predicts every result and compares it with what the block returns.
// Depends on boc_pkg and on the channel interfaces in boc_intf.sv.

module boc_result_monitor
   import boc_pkg::*;
#(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   boc_req_if                        req,
   boc_rsp_if                        rsp,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   input  logic                      pready,
   output int unsigned               failures,
   output int unsigned               outstanding
);

   typedef struct packed {
      logic                   accepted;
      logic [ERROR_WIDTH-1:0] error_code;
      logic [PC_WIDTH-1:0]    pc;
   } verdict_type;

   cfg_type               limits;
   logic [KIND_WIDTH-1:0] kind_table [TABLE_DEPTH];
   verdict_type           awaited_verdicts [$];

   function automatic bit reg_valid(input longint r);
      return r >= 0 && r < longint'(limits.reg_count);
   endfunction

   function automatic bit target_valid(input longint t);
      return t >= 0 && t < longint'(limits.insn_count);
   endfunction

   function automatic bit index_valid(input longint k);
      return k >= 0 && k < longint'(limits.const_count);
   endfunction

   // An index inside the constant count but past the end of the table fails every kind.
   function automatic bit constant_is(input longint k, input logic [KIND_WIDTH-1:0] kind);
      if (!index_valid(k) || k >= TABLE_DEPTH)
         return 1'b0;
      return kind_table[int'(k)] == kind;
   endfunction

   function automatic logic [ERROR_WIDTH-1:0] predict_error_code(
      input logic [OPCODE_WIDTH-1:0] op,
      input longint                  a,
      input longint                  b,
      input longint                  c
   );
      longint n;
      n = longint'(limits.reg_count);
      case (op)
         OP_LOADK:
            return (reg_valid(a) && index_valid(b)) ? ERR_NONE : ERR_LOADK;
         OP_MOVE:
            return (reg_valid(a) && reg_valid(b)) ? ERR_NONE : ERR_MOVE;
         OP_TUPLE:
            return (reg_valid(a) && b >= 0 && b <= n && c >= 0 && c <= n - b)
                   ? ERR_NONE : ERR_TUPLE;
         OP_JUMP:
            return target_valid(a) ? ERR_NONE : ERR_JUMP;
         OP_CALL:
            return (reg_valid(a) && constant_is(b, KIND_FUNC) && reg_valid(c))
                   ? ERR_NONE : ERR_CALL;
         OP_TAILCALL:
            return (constant_is(a, KIND_FUNC) && reg_valid(b)) ? ERR_NONE : ERR_TAILCALL;
         OP_RETURN:
            return reg_valid(a) ? ERR_NONE : ERR_RETURN;
         OP_TESTATOM:
            return (reg_valid(a) && constant_is(b, KIND_ATOM) && target_valid(c))
                   ? ERR_NONE : ERR_TESTATOM;
         OP_TESTINT:
            return (reg_valid(a) && constant_is(b, KIND_INT) && target_valid(c))
                   ? ERR_NONE : ERR_TESTINT;
         OP_TESTEQ:
            return (reg_valid(a) && reg_valid(b) && target_valid(c)) ? ERR_NONE : ERR_TESTEQ;
         OP_TESTARITY:
            return (reg_valid(a) && b >= 0 && target_valid(c)) ? ERR_NONE : ERR_TESTARITY;
         OP_GETELEM:
            return (reg_valid(a) && reg_valid(b) && c >= 0) ? ERR_NONE : ERR_GETELEM;
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_LT, OP_LE, OP_GT, OP_GE:
            return (reg_valid(a) && reg_valid(b) && reg_valid(c)) ? ERR_NONE : ERR_ARITH;
         OP_FAIL:
            return index_valid(a) ? ERR_NONE : ERR_FAIL;
         OP_SELF, OP_MAKEREF:
            return reg_valid(a) ? ERR_NONE : ERR_PROC_DEST;
         OP_SEND:
            return (reg_valid(a) && reg_valid(b) && reg_valid(c)) ? ERR_NONE : ERR_SEND;
         OP_SPAWN:
            return (reg_valid(a) && constant_is(b, KIND_FUNC) && reg_valid(c))
                   ? ERR_NONE : ERR_SPAWN;
         OP_RECVBEGIN, OP_RECVNEXT:
            return (reg_valid(a) && reg_valid(b) && a != b) ? ERR_NONE : ERR_RECV_DEST;
         OP_RECVWAIT, OP_RECVWAITDEADLINE:
            return target_valid(a) ? ERR_NONE : ERR_RECV_RETRY;
         OP_RECVDEADLINE:
            return reg_valid(a) ? ERR_NONE : ERR_RECV_DLINE;
         OP_EXIT:
            return reg_valid(a) ? ERR_NONE : ERR_EXIT;
         OP_PRINT:
            return (reg_valid(a) && reg_valid(b)) ? ERR_NONE : ERR_PRINT;
         OP_EPRINT:
            return (reg_valid(a) && reg_valid(b)) ? ERR_NONE : ERR_EPRINT;
         OP_GUARD:
            return target_valid(a) ? ERR_NONE : ERR_GUARD;
         OP_ISTYPE:
            return (reg_valid(a) && reg_valid(b) && c >= 0 && c <= longint'(TERM_KIND_MAX))
                   ? ERR_NONE : ERR_ISTYPE;
         OP_RECVTAKE, OP_GUARDEND, OP_NOP:
            return ERR_NONE;
         default:
            return ERR_OPCODE;
      endcase
   endfunction

   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      if (reset) begin
         limits.reg_count   = 1;
         limits.insn_count  = 1;
         limits.const_count = 0;
         awaited_verdicts.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               {CSR_IDX_REG_COUNT, 2'b00}:   limits.reg_count   = pwdata[REG_CNT_WIDTH-1:0];
               {CSR_IDX_INSN_COUNT, 2'b00}:  limits.insn_count  = pwdata[CNT_WIDTH-1:0];
               {CSR_IDX_CONST_COUNT, 2'b00}: limits.const_count = pwdata[CNT_WIDTH-1:0];
               default: ;
            endcase
         end

         // A result trails its item through stage one and the result register, so the oldest
         // expectation is settled before this edge's item is added.
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.accepted, rsp.error_code, rsp.pc_out};
            if (awaited_verdicts.size() == 0) begin
               failures++;
               $display("%0t: unexpected result: accepted %0b error %0d pc %0d",
                        $time, got.accepted, got.error_code, got.pc);
            end else begin
               want = awaited_verdicts.pop_front();
               if (got !== want) begin
                  failures++;
                  $display({"%0t: expected accepted %0b error %0d pc %0d, ",
                            "got accepted %0b error %0d pc %0d"},
                           $time, want.accepted, want.error_code, want.pc,
                           got.accepted, got.error_code, got.pc);
               end
            end
         end

         if (req.valid && req.ready) begin
            want.pc = req.pc_tag;
            if (req.command == CMD_WRITE_KIND) begin
               want.error_code = ERR_NONE;
               want.accepted   = int'(req.pc_tag) < TABLE_DEPTH;
               if (want.accepted)
                  kind_table[req.pc_tag] = req.const_kind;
            end else begin
               want.error_code = predict_error_code(req.opcode, req.operand_a,
                                                    req.operand_b, req.operand_c);
               want.accepted   = want.error_code == ERR_NONE;
            end
            awaited_verdicts.push_back(want);
         end
      end
      outstanding = awaited_verdicts.size();
   end

endmodule

/* tb/testbench.sv */
// Top of the bytecode operand checker testbench: clock, reset, configuration writes,
// item stimulus with bursts and stalls, and the final verdict.
// Depends on boc_pkg, boc_intf.sv, the block itself and boc_result_monitor.

module testbench;
   import boc_pkg::*;

   localparam int TABLE_DEPTH = 4096;
   localparam int ITEMS_PER_PHASE = 250;
   // Kind code 3 has no name in the package; it stands for any other constant.
   localparam logic [KIND_WIDTH-1:0] KIND_OTHER = 2'd3;

   logic clock = 1'b0;
   logic reset;

   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int unsigned mismatch_count;
   int unsigned results_awaited;

   boc_req_if req_if ();
   boc_rsp_if rsp_if ();

   bytecode_operand_checker #(
      .MAX_ITEMS (TABLE_DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   boc_result_monitor #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) monitor (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .pready      (pready),
      .failures    (mismatch_count),
      .outstanding (results_awaited)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The stimulus keeps its own view of the limits and of which table entries hold a
   // kind. It uses these only to steer operands towards interesting values and to make
   // sure that no check ever looks up an entry that was never written.
   cfg_type               shadow_limits;
   bit                    kind_written [TABLE_DEPTH];
   logic [KIND_WIDTH-1:0] shadow_kind [TABLE_DEPTH];
   int                    written_indexes [$];
   int                    burst_left = 0;
   logic [PC_WIDTH-1:0]   next_pc = '0;

   // Presents one item at the falling edge and holds it until the block takes it. The
   // sender works in bursts; a gap of idle cycles may fall in front of a burst. The task
   // returns at the falling edge after acceptance with valid still high, so the caller
   // either puts up the next item or drops valid in that same step.
   task automatic send_item(
      input logic                            command,
      input logic [PC_WIDTH-1:0]             tag,
      input logic [OPCODE_WIDTH-1:0]         op,
      input logic signed [OPERAND_WIDTH-1:0] a,
      input logic signed [OPERAND_WIDTH-1:0] b,
      input logic signed [OPERAND_WIDTH-1:0] c,
      input logic [KIND_WIDTH-1:0]           kind
   );
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_if.valid      = 1'b1;
      req_if.command    = command;
      req_if.pc_tag     = tag;
      req_if.opcode     = op;
      req_if.operand_a  = a;
      req_if.operand_b  = b;
      req_if.operand_c  = c;
      req_if.const_kind = kind;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      @(negedge clock);
   endtask

   // Checks take a fresh position tag each; the kind field is ignored but still toggled.
   task automatic check_op(
      input logic [OPCODE_WIDTH-1:0]         op,
      input logic signed [OPERAND_WIDTH-1:0] a,
      input logic signed [OPERAND_WIDTH-1:0] b,
      input logic signed [OPERAND_WIDTH-1:0] c
   );
      send_item(CMD_CHECK, next_pc, op, a, b, c, $urandom_range(0, 3));
      next_pc++;
   endtask

   // A table write carries random rubbish in the fields that it does not use.
   task automatic write_kind(input logic [PC_WIDTH-1:0] index,
                             input logic [KIND_WIDTH-1:0] kind);
      send_item(CMD_WRITE_KIND, index, $urandom, $urandom, $urandom, $urandom, kind);
      if (!kind_written[index])
         written_indexes.push_back(int'(index));
      kind_written[index] = 1'b1;
      shadow_kind[index]  = kind;
   endtask

   // Drops valid and waits until every result that is owed has come back.
   task automatic wait_for_results();
      req_if.valid = 1'b0;
      while (results_awaited != 0)
         @(negedge clock);
   endtask

   // One register write: a setup phase, then an access phase held until pready.
   task automatic write_register(input logic [1:0] index,
                                 input logic [CSR_DATA_WIDTH-1:0] value);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {index, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   // The limits only change while the block is idle.
   task automatic set_limits(input int regs, input int insns, input int consts);
      wait_for_results();
      write_register(CSR_IDX_REG_COUNT, regs);
      write_register(CSR_IDX_INSN_COUNT, insns);
      write_register(CSR_IDX_CONST_COUNT, consts);
      shadow_limits.reg_count   = regs;
      shadow_limits.insn_count  = insns;
      shadow_limits.const_count = consts;
   endtask

   // Mostly an index inside the count, otherwise one of the edges: the count itself,
   // one below it, minus one, or an arbitrary or extreme 32-bit value.
   function automatic logic signed [OPERAND_WIDTH-1:0] pick_bounded(input int count);
      int r;
      r = $urandom_range(0, 21);
      if (count > 0 && r < 16)
         return $urandom_range(0, count - 1);
      case (r % 6)
         0: return count;
         1: return count - 1;
         2: return -1;
         3: return $urandom;
         4: return 32'h8000_0000;
         default: return 32'h7FFF_FFFF;
      endcase
   endfunction

   // A constant index that would make the block look up a table entry never written is
   // swapped for one that was written, or for the count itself, which is out of range.
   function automatic logic signed [OPERAND_WIDTH-1:0] avoid_unwritten(
      input logic signed [OPERAND_WIDTH-1:0] k
   );
      if (k >= 0 && k < int'(shadow_limits.const_count) && k < TABLE_DEPTH
          && !kind_written[k]) begin
         if (written_indexes.size() > 0)
            return written_indexes[$urandom_range(0, written_indexes.size() - 1)];
         return shadow_limits.const_count;
      end
      return k;
   endfunction

   // Prefers a written entry of the wanted kind so that kind checks pass often enough.
   function automatic logic signed [OPERAND_WIDTH-1:0] pick_constant(
      input logic [KIND_WIDTH-1:0] kind
   );
      int idx;
      if (written_indexes.size() > 0 && $urandom_range(0, 4) != 0) begin
         for (int t = 0; t < 4; t++) begin
            idx = written_indexes[$urandom_range(0, written_indexes.size() - 1)];
            if (shadow_kind[idx] == kind)
               break;
         end
         return avoid_unwritten(idx);
      end
      return avoid_unwritten(pick_bounded(shadow_limits.const_count));
   endfunction

   // A quantity that only has to be non-negative, now and then a negative one.
   function automatic logic signed [OPERAND_WIDTH-1:0] pick_non_negative();
      case ($urandom_range(0, 5))
         0: return -$urandom_range(1, 5);
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         default: return $urandom_range(0, 1000);
      endcase
   endfunction

   // One phase of random items under one setting of the limits. About one item in five
   // writes the kind table; most writes land in the low entries so that they are used.
   task automatic run_phase(input int regs, input int insns, input int consts,
                            input int count);
      logic [OPCODE_WIDTH-1:0]         op;
      logic signed [OPERAND_WIDTH-1:0] a;
      logic signed [OPERAND_WIDTH-1:0] b;
      logic signed [OPERAND_WIDTH-1:0] c;
      int                              n;
      set_limits(regs, insns, consts);
      repeat (count) begin
         if ($urandom_range(0, 4) == 0) begin
            write_kind(($urandom_range(0, 1) == 0) ? $urandom_range(0, 63) : $urandom,
                       $urandom_range(0, 3));
         end else begin
            op = ($urandom_range(0, 9) == 0) ? $urandom_range(OP_NOP + 1, 63)
                                             : $urandom_range(0, OP_NOP);
            n  = shadow_limits.reg_count;
            a  = pick_bounded(n);
            b  = pick_bounded(n);
            c  = pick_bounded(n);
            case (op)
               OP_LOADK: b = pick_bounded(shadow_limits.const_count);
               OP_TUPLE: begin
                  if ($urandom_range(0, 3) != 0) begin
                     b = $urandom_range(0, n);
                     c = $urandom_range(0, n - b);
                  end else begin
                     case ($urandom_range(0, 3))
                        0: begin b = n + 1; c = 0; end
                        1: begin b = $urandom_range(0, n); c = n - b + 1; end
                        2: begin b = -1; c = 0; end
                        default: begin b = $urandom; c = $urandom; end
                     endcase
                  end
               end
               OP_JUMP, OP_RECVWAIT, OP_RECVWAITDEADLINE, OP_GUARD:
                  a = pick_bounded(shadow_limits.insn_count);
               OP_CALL, OP_SPAWN: b = pick_constant(KIND_FUNC);
               OP_TAILCALL: a = pick_constant(KIND_FUNC);
               OP_TESTATOM: begin
                  b = pick_constant(KIND_ATOM);
                  c = pick_bounded(shadow_limits.insn_count);
               end
               OP_TESTINT: begin
                  b = pick_constant(KIND_INT);
                  c = pick_bounded(shadow_limits.insn_count);
               end
               OP_TESTEQ: c = pick_bounded(shadow_limits.insn_count);
               OP_TESTARITY: begin
                  b = pick_non_negative();
                  c = pick_bounded(shadow_limits.insn_count);
               end
               OP_GETELEM: c = pick_non_negative();
               OP_FAIL: a = pick_bounded(shadow_limits.const_count);
               OP_RECVBEGIN, OP_RECVNEXT: if ($urandom_range(0, 3) == 0) b = a;
               OP_ISTYPE: c = ($urandom_range(0, 4) != 0) ? $urandom_range(0, TERM_KIND_MAX)
                                                          : pick_bounded(TERM_KIND_MAX + 1);
               default: ;
            endcase
            send_item(CMD_CHECK, $urandom, op, a, b, c, $urandom_range(0, 3));
         end
      end
   endtask

   // The receiver is mostly ready but stalls now and then at random, and now and
   // then takes a long calm stretch with no stall at all.
   initial begin
      int stall_left;
      int calm_left;
      stall_left   = 0;
      calm_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = 1'b1;
            if (calm_left > 0)
               calm_left--;
            else if ($urandom_range(0, 3) == 0)
               stall_left = $urandom_range(1, 7);
            else if ($urandom_range(0, 49) == 0)
               calm_left = $urandom_range(20, 120);
         end
      end
   end

   initial begin
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_if.valid      = 1'b0;
      req_if.command    = CMD_CHECK;
      req_if.pc_tag     = '0;
      req_if.opcode     = OP_NOP;
      req_if.operand_a  = '0;
      req_if.operand_b  = '0;
      req_if.operand_c  = '0;
      req_if.const_kind = KIND_INT;
      shadow_limits.reg_count   = 1;
      shadow_limits.insn_count  = 1;
      shadow_limits.const_count = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Under the limits left by reset: a single register, a single instruction and an
      // empty constant table, so any constant index is out of range.
      check_op(OP_MOVE, 0, 0, 0);
      check_op(OP_MOVE, 1, 0, 0);
      check_op(OP_JUMP, 0, 0, 0);
      check_op(OP_JUMP, -1, 0, 0);
      check_op(OP_LOADK, 0, 0, 0);

      // A small function in a module whose constant count reaches the end of the table.
      set_limits(16, 32, TABLE_DEPTH);
      write_kind(0, KIND_INT);
      write_kind(1, KIND_ATOM);
      write_kind(2, KIND_FUNC);
      write_kind(TABLE_DEPTH - 1, KIND_OTHER);
      check_op(OP_LOADK, 15, TABLE_DEPTH - 1, 0);
      // Tuple ranges that just fit, and one that runs one register past the end.
      check_op(OP_TUPLE, 0, 16, 0);
      check_op(OP_TUPLE, 0, 0, 16);
      check_op(OP_TUPLE, 0, 8, 9);
      check_op(OP_CALL, 0, 2, 15);
      check_op(OP_CALL, 0, 1, 0);
      // This index equals the constant count and lies past the end of the table, so it is out of range.
      check_op(OP_CALL, 0, TABLE_DEPTH, 0);
      check_op(OP_TAILCALL, 2, 0, 0);
      check_op(OP_TESTATOM, 0, 1, 31);
      check_op(OP_TESTINT, 0, 0, 32);
      check_op(OP_ISTYPE, 0, 1, TERM_KIND_MAX);
      check_op(OP_ISTYPE, 0, 1, TERM_KIND_MAX + 1);
      check_op(OP_RECVBEGIN, 3, 3, 0);
      check_op(OP_TESTARITY, 0, -1, 0);
      check_op(OP_GETELEM, 0, 0, 32'h8000_0000);
      check_op(OP_MOVE, 32'h7FFF_FFFF, 0, 0);
      check_op(OP_NOP + 1, 0, 0, 0);
      check_op((1 << OPCODE_WIDTH) - 1, 0, 0, 0);

      // Random phases: the nominal maxima, the minima, all counts zero, the widest values
      // that the registers hold, and a few ordinary settings.
      run_phase(256, 4096, 4096, ITEMS_PER_PHASE);
      run_phase(1, 1, 1, ITEMS_PER_PHASE);
      run_phase(0, 0, 0, ITEMS_PER_PHASE);
      run_phase(511, 8191, 8191, ITEMS_PER_PHASE);
      run_phase(8, 16, 64, ITEMS_PER_PHASE);
      run_phase($urandom_range(1, 256), $urandom_range(1, 4096), $urandom_range(0, 4096),
                ITEMS_PER_PHASE);
      run_phase(256, 1, 4095, ITEMS_PER_PHASE);

      // Every item yields a result; the extra cycles catch strays.
      wait_for_results();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // Far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
